FILE: rtl/lge_pkg.sv
// Package for the life grid engine: request codes, configuration indexes,
// default sizes and the command/status structs between controller and datapath.
// No dependencies.
package lge_pkg;

   // Field widths fixed by the interface
   localparam int REQ_W   = 2;
   localparam int COORD_W = 7;
   localparam int SIZE_W  = 8;
   localparam int CSR_IDX_W = 1;

   // Default grid storage, one side
   localparam int MAX_GRID_DEFAULT = 128;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_TOGGLE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
   localparam logic [REQ_W-1:0] REQ_STEP   = 2'd3;

   // Configuration register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_COLS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_ROWS = 1'd1;
   localparam logic [SIZE_W-1:0]    ACTIVE_COLS_RESET = 8'd96;
   localparam logic [SIZE_W-1:0]    ACTIVE_ROWS_RESET = 8'd96;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;      // latch request word, read its row
      logic clr_write;   // write a zero row during the clearing pass
      logic gen_start;   // clear upper window row, read row 0
      logic gen_prime;   // load row 0 into center of window
      logic gen_fetch;   // read row below the current one
      logic gen_calc;    // compute and write back current row, shift window
      logic gen_finish;  // load generation result word
      logic cell_finish; // update cell, load cell result word
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic zero_size;   // no active cell
      logic last_row;    // row counter at last active row
      logic clr_last;    // clearing pass at last storage row
      logic out_busy;    // result word waiting and stalled
   } sts_type;

endpackage

FILE: rtl/lge_ctrl.sv
// Controller of the life grid engine: sequences reset clearing, cell
// requests and generation sweeps. Uses lge_pkg command and status structs.
module lge_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [lge_pkg::REQ_W-1:0]  req_type,
   output logic                       req_stall,
   input  lge_pkg::sts_type           sts,
   output lge_pkg::cmd_type           cmd
);

   localparam logic [2:0] ST_CLEAR     = 3'd0;
   localparam logic [2:0] ST_IDLE      = 3'd1;
   localparam logic [2:0] ST_CELL      = 3'd2;
   localparam logic [2:0] ST_GEN_PRIME = 3'd3;
   localparam logic [2:0] ST_GEN_FETCH = 3'd4;
   localparam logic [2:0] ST_GEN_CALC  = 3'd5;
   localparam logic [2:0] ST_GEN_DONE  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Take request words only when idle
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_type == lge_pkg::REQ_STEP) begin
                  cmd.gen_start = 1'b1;
                  state_in = sts.zero_size ? ST_GEN_DONE : ST_GEN_PRIME;
               end else begin
                  state_in = ST_CELL;
               end
            end
         end
         ST_CELL: begin
            if (!sts.out_busy) begin
               cmd.cell_finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_GEN_PRIME: begin
            cmd.gen_prime = 1'b1;
            state_in = ST_GEN_FETCH;
         end
         ST_GEN_FETCH: begin
            cmd.gen_fetch = 1'b1;
            state_in = ST_GEN_CALC;
         end
         ST_GEN_CALC: begin
            cmd.gen_calc = 1'b1;
            state_in = sts.last_row ? ST_GEN_DONE : ST_GEN_FETCH;
         end
         ST_GEN_DONE: begin
            if (!sts.out_busy) begin
               cmd.gen_finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   // Only one source drives the row write port
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_write, cmd.gen_calc, cmd.cell_finish}))
      else $error("more than one row write source");

   // A result word is loaded only when the output register can take it
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (cmd.cell_finish || cmd.gen_finish) |-> !sts.out_busy)
      else $error("result loaded over a stalled word");

   // The sweep ends after the last active row
   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GEN_CALC && sts.last_row) |=> (state_ff == ST_GEN_DONE))
      else $error("generation sweep did not finish at the last row");
`endif

endmodule

FILE: rtl/lge_datapath.sv
// Datapath of the life grid engine: row memory, three-row window, the
// lane-parallel B3/S23 row update and the result register. Uses lge_pkg.
module lge_datapath #(
   parameter int MAX_GRID = lge_pkg::MAX_GRID_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lge_pkg::cmd_type             cmd,
   output lge_pkg::sts_type             sts,
   input  logic [lge_pkg::REQ_W-1:0]    req_type,
   input  logic [lge_pkg::COORD_W-1:0]  req_cell_col,
   input  logic [lge_pkg::COORD_W-1:0]  req_cell_row,
   input  logic                         req_write_value,
   input  logic [lge_pkg::SIZE_W-1:0]   active_cols,
   input  logic [lge_pkg::SIZE_W-1:0]   active_rows,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_cell_alive,
   output logic                         rsp_generation_done,
   output logic                         rsp_coord_out_of_range
);

   localparam int AW = $clog2(MAX_GRID);
   localparam int EW = $clog2(MAX_GRID + 1);

   // Row memory, one row of cells per word
   logic [MAX_GRID-1:0] grid_mem [MAX_GRID];
   logic [MAX_GRID-1:0] rd_data_ff;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [MAX_GRID-1:0] wr_data;

   // Latched request word
   logic [lge_pkg::REQ_W-1:0]   type_ff,  type_in;
   logic [lge_pkg::COORD_W-1:0] col_ff,   col_in;
   logic [lge_pkg::COORD_W-1:0] row_ff,   row_in;
   logic                        wval_ff,  wval_in;

   // Row counter and window of old rows
   logic [AW-1:0]       cnt_ff, cnt_in;
   logic [MAX_GRID-1:0] win_up_ff, win_up_in;
   logic [MAX_GRID-1:0] win_mid_ff, win_mid_in;

   // Result register
   logic rsp_valid_ff, rsp_valid_in;
   logic alive_ff, alive_in;
   logic gen_ff, gen_in;
   logic oor_ff, oor_in;

   logic [EW-1:0]       eff_cols;
   logic [EW-1:0]       eff_rows;
   logic [MAX_GRID-1:0] col_mask;
   logic [MAX_GRID-1:0] row_below;
   logic [MAX_GRID+1:0] pad_up, pad_mid, pad_dn;
   logic [MAX_GRID-1:0] life_row;
   logic [MAX_GRID-1:0] gen_row;
   logic [AW-1:0]       col_idx;
   logic                in_range;
   logic                old_bit;
   logic                new_bit;
   logic [MAX_GRID-1:0] cell_row_new;
   logic                cell_writes;

   // Clamp active sizes to the storage
   assign eff_cols = (32'(active_cols) > 32'(MAX_GRID)) ? EW'(MAX_GRID) : EW'(active_cols);
   assign eff_rows = (32'(active_rows) > 32'(MAX_GRID)) ? EW'(MAX_GRID) : EW'(active_rows);

   always_comb begin
      for (int c = 0; c < MAX_GRID; c++) begin
         col_mask[c] = (32'(c) < 32'(eff_cols));
      end
   end

   // Status
   assign in_range = (32'(col_ff) < 32'(eff_cols)) && (32'(row_ff) < 32'(eff_rows));
   assign sts.zero_size = (eff_cols == '0) || (eff_rows == '0);
   assign sts.last_row  = ((32'(cnt_ff) + 32'd1) == 32'(eff_rows));
   assign sts.clr_last  = (cnt_ff == AW'(MAX_GRID - 1));
   assign sts.out_busy  = rsp_valid_ff && rsp_stall;

   // Row update: count neighbors per lane, edges beyond the active area dead
   assign row_below = sts.last_row ? '0 : rd_data_ff;
   assign pad_up  = {1'b0, win_up_ff  & col_mask, 1'b0};
   assign pad_mid = {1'b0, win_mid_ff & col_mask, 1'b0};
   assign pad_dn  = {1'b0, row_below  & col_mask, 1'b0};

   always_comb begin
      logic [3:0] n;
      for (int c = 0; c < MAX_GRID; c++) begin
         n = 4'(pad_up[c]) + 4'(pad_up[c+1]) + 4'(pad_up[c+2])
           + 4'(pad_mid[c]) + 4'(pad_mid[c+2])
           + 4'(pad_dn[c]) + 4'(pad_dn[c+1]) + 4'(pad_dn[c+2]);
         life_row[c] = (n == 4'd3) || (win_mid_ff[c] && (n == 4'd2));
      end
   end

   // Keep stored cells beyond the active columns
   assign gen_row = (life_row & col_mask) | (win_mid_ff & ~col_mask);

   // Cell update for write and toggle
   assign col_idx = AW'(col_ff);
   assign old_bit = rd_data_ff[col_idx];
   always_comb begin
      unique case (type_ff)
         lge_pkg::REQ_WRITE:  new_bit = wval_ff;
         lge_pkg::REQ_TOGGLE: new_bit = ~old_bit;
         default:             new_bit = old_bit;
      endcase
      cell_row_new = rd_data_ff;
      cell_row_new[col_idx] = new_bit;
   end
   assign cell_writes = in_range && ((type_ff == lge_pkg::REQ_WRITE) ||
                                     (type_ff == lge_pkg::REQ_TOGGLE));

   // Read address select
   always_comb begin
      priority if (cmd.gen_start) begin
         rd_addr = '0;
      end else if (cmd.gen_fetch) begin
         rd_addr = cnt_ff + AW'(1);
      end else if (cmd.accept) begin
         rd_addr = AW'(req_cell_row);
      end else begin
         rd_addr = AW'(row_ff);
      end
   end

   // Write port select
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff;
      wr_data = '0;
      priority if (cmd.clr_write) begin
         wr_en = 1'b1;
      end else if (cmd.gen_calc) begin
         wr_en   = 1'b1;
         wr_data = gen_row;
      end else if (cmd.cell_finish && cell_writes) begin
         wr_en   = 1'b1;
         wr_addr = AW'(row_ff);
         wr_data = cell_row_new;
      end else begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= grid_mem[rd_addr];
   end

   // Next values of request latch, counter and window
   always_comb begin
      type_in    = type_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      wval_in    = wval_ff;
      cnt_in     = cnt_ff;
      win_up_in  = win_up_ff;
      win_mid_in = win_mid_ff;
      if (cmd.accept) begin
         type_in = req_type;
         col_in  = req_cell_col;
         row_in  = req_cell_row;
         wval_in = req_write_value;
      end
      if (cmd.clr_write) begin
         cnt_in = sts.clr_last ? '0 : cnt_ff + AW'(1);
      end
      if (cmd.gen_start) begin
         cnt_in    = '0;
         win_up_in = '0;
      end
      if (cmd.gen_prime) begin
         win_mid_in = rd_data_ff;
      end
      if (cmd.gen_calc) begin
         cnt_in     = cnt_ff + AW'(1);
         win_up_in  = win_mid_ff;
         win_mid_in = rd_data_ff;
      end
   end

   // Result register: load a word, drop it once taken
   always_comb begin
      alive_in = alive_ff;
      gen_in   = gen_ff;
      oor_in   = oor_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.cell_finish) begin
         rsp_valid_in = 1'b1;
         alive_in = in_range && new_bit;
         gen_in   = 1'b0;
         oor_in   = !in_range;
      end else if (cmd.gen_finish) begin
         rsp_valid_in = 1'b1;
         alive_in = 1'b0;
         gen_in   = 1'b1;
         oor_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      type_ff    <= type_in;
      col_ff     <= col_in;
      row_ff     <= row_in;
      wval_ff    <= wval_in;
      win_up_ff  <= win_up_in;
      win_mid_ff <= win_mid_in;
      alive_ff   <= alive_in;
      gen_ff     <= gen_in;
      oor_ff     <= oor_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_cell_alive         = alive_ff;
   assign rsp_generation_done    = gen_ff;
   assign rsp_coord_out_of_range = oor_ff;

`ifndef SYNTH
   // At most one result flag in a word
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($countones({alive_ff, gen_ff, oor_ff}) <= 1))
      else $error("result word carries conflicting flags");
`endif

endmodule

FILE: rtl/life_grid_engine.sv
// Life grid engine top level: size registers and the controller/datapath pair.
// Depends on lge_pkg, lge_ctrl and lge_datapath.
//
// A grid of MAX_GRID x MAX_GRID one-bit cells running Conway's Life (B3/S23)
// on the active area set by active_cols/active_rows (csr index 0 and 1),
// with cells outside that area counting as dead. After reset the block runs
// a clearing pass over all MAX_GRID rows (one row per cycle) during which it
// stalls requests. A write, toggle or read is accepted with the row read,
// then the cell is updated and the result loaded once the output register
// is free. A generation step runs accept, window prime, then per row a
// registered read from the single row memory and an update of the whole
// active row, then the result, over active_rows clamped to MAX_GRID rows
// (from accept straight to the result when no cell is active). Every request
// gives exactly one result word; a new request word is taken while a finished
// result still waits on rsp_stall. Sizes may only change while idle.
module life_grid_engine #(
   parameter int MAX_GRID = lge_pkg::MAX_GRID_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [lge_pkg::REQ_W-1:0]       req_type,
   input  logic [lge_pkg::COORD_W-1:0]     req_cell_col,
   input  logic [lge_pkg::COORD_W-1:0]     req_cell_row,
   input  logic                            req_write_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_cell_alive,
   output logic                            rsp_generation_done,
   output logic                            rsp_coord_out_of_range,
   input  logic                            csr_wr_en,
   input  logic [lge_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lge_pkg::SIZE_W-1:0]      csr_wdata
);

   logic [lge_pkg::SIZE_W-1:0] cols_ff, cols_in;
   logic [lge_pkg::SIZE_W-1:0] rows_ff, rows_in;
   lge_pkg::cmd_type cmd;
   lge_pkg::sts_type sts;

   // Size registers
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lge_pkg::CSR_ACTIVE_COLS: cols_in = csr_wdata;
            lge_pkg::CSR_ACTIVE_ROWS: rows_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= lge_pkg::ACTIVE_COLS_RESET;
         rows_ff <= lge_pkg::ACTIVE_ROWS_RESET;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   lge_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lge_datapath #(
      .MAX_GRID (MAX_GRID)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_type               (req_type),
      .req_cell_col           (req_cell_col),
      .req_cell_row           (req_cell_row),
      .req_write_value        (req_write_value),
      .active_cols            (cols_ff),
      .active_rows            (rows_ff),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_cell_alive         (rsp_cell_alive),
      .rsp_generation_done    (rsp_generation_done),
      .rsp_coord_out_of_range (rsp_coord_out_of_range)
   );

endmodule

FILE: tb/life_grid_engine_tb.sv
// Self-checking testbench for life_grid_engine: cell write/toggle/read and Life
// generations, checked word by word against a built-in grid model.
// Depends on lge_pkg and the life_grid_engine RTL.
module life_grid_engine_tb;

   localparam int GRID_SIDE    = lge_pkg::MAX_GRID_DEFAULT;
   localparam int LIMIT_CYCLES = 400000;
   localparam int RANDOM_ITEMS = 70;

   typedef struct packed {
      logic cell_alive;
      logic generation_done;
      logic coord_out_of_range;
   } life_result_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [lge_pkg::REQ_W-1:0]     req_type;
   logic [lge_pkg::COORD_W-1:0]   req_cell_col;
   logic [lge_pkg::COORD_W-1:0]   req_cell_row;
   logic                          req_write_value;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic                          rsp_cell_alive;
   logic                          rsp_generation_done;
   logic                          rsp_coord_out_of_range;
   logic                          csr_wr_en;
   logic [lge_pkg::CSR_IDX_W-1:0] csr_index;
   logic [lge_pkg::SIZE_W-1:0]    csr_wdata;

   // Grid model: cell state and size registers
   logic [GRID_SIDE-1:0]       life_cells [GRID_SIDE];
   logic [GRID_SIDE-1:0]       prev_cells [GRID_SIDE];
   logic [lge_pkg::SIZE_W-1:0] model_cols;
   logic [lge_pkg::SIZE_W-1:0] model_rows;

   life_result_type expected_results [$];
   int  error_count = 0;
   int  items_sent  = 0;
   int  cycle_count = 0;
   bit  idling_on   = 1'b1;
   int  stall_left  = 0;

   life_grid_engine i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_type               (req_type),
      .req_cell_col           (req_cell_col),
      .req_cell_row           (req_cell_row),
      .req_write_value        (req_write_value),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_cell_alive         (rsp_cell_alive),
      .rsp_generation_done    (rsp_generation_done),
      .rsp_coord_out_of_range (rsp_coord_out_of_range),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Clamp a size register to the storage side
   function automatic int grid_extent(input logic [lge_pkg::SIZE_W-1:0] size);
      return (size > GRID_SIDE) ? GRID_SIDE : int'(size);
   endfunction

   // Advance one generation from a snapshot; cells off the active area count dead
   function automatic void advance_generation();
      int   rows, cols, live, rr, cc;
      logic old;
      rows = grid_extent(model_rows);
      cols = grid_extent(model_cols);
      prev_cells = life_cells;
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < cols; c++) begin
            live = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  rr = r + dr;
                  cc = c + dc;
                  if ((dr != 0 || dc != 0) && rr >= 0 && rr < rows &&
                      cc >= 0 && cc < cols)
                     live += prev_cells[rr][cc];
               end
            end
            old = prev_cells[r][c];
            if (!old && live == 3)
               life_cells[r][c] = 1'b1;
            else if (old && (live < 2 || live > 3))
               life_cells[r][c] = 1'b0;
         end
      end
   endfunction

   // Apply one accepted request to the grid model and queue its result word
   function automatic void predict_request(input logic [lge_pkg::REQ_W-1:0] kind,
                                           input int col, input int row,
                                           input logic wval);
      life_result_type res;
      res = '0;
      if (kind == lge_pkg::REQ_STEP) begin
         advance_generation();
         res.generation_done = 1'b1;
      end else if (col >= grid_extent(model_cols) || row >= grid_extent(model_rows)) begin
         res.coord_out_of_range = 1'b1;
      end else begin
         if (kind == lge_pkg::REQ_WRITE)
            life_cells[row][col] = wval;
         else if (kind == lge_pkg::REQ_TOGGLE)
            life_cells[row][col] = ~life_cells[row][col];
         res.cell_alive = life_cells[row][col];
      end
      expected_results.push_back(res);
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Send one request word; hold it until the block takes it
   task automatic send_request(input logic [lge_pkg::REQ_W-1:0] kind, input int col,
                               input int row, input logic wval);
      if (idling_on && $urandom_range(3, 0) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(8, 1)) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_type        = kind;
      req_cell_col    = col[lge_pkg::COORD_W-1:0];
      req_cell_row    = row[lge_pkg::COORD_W-1:0];
      req_write_value = wval;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(kind, col, row, wval);
      items_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_step();
      send_request(lge_pkg::REQ_STEP, int'($urandom_range(127, 0)),
                   int'($urandom_range(127, 0)), 1'($urandom_range(1, 0)));
   endtask

   // Hold off until every expected word has come back
   task automatic wait_drain();
      while (expected_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_size(input logic [lge_pkg::CSR_IDX_W-1:0] idx,
                             input logic [lge_pkg::SIZE_W-1:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      if (idx == lge_pkg::CSR_ACTIVE_COLS)
         model_cols = value;
      else
         model_rows = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic set_grid_size(input logic [lge_pkg::SIZE_W-1:0] cols,
                                input logic [lge_pkg::SIZE_W-1:0] rows);
      wait_drain();
      write_size(lge_pkg::CSR_ACTIVE_COLS, cols);
      write_size(lge_pkg::CSR_ACTIVE_ROWS, rows);
   endtask

   // Random coordinate inside the active area, anywhere when the area is empty
   function automatic int pick_coord(input logic [lge_pkg::SIZE_W-1:0] size);
      int extent;
      extent = grid_extent(size);
      return (extent > 0) ? int'($urandom_range(extent - 1, 0))
                          : int'($urandom_range(127, 0));
   endfunction

   // Mostly small grids, some large ones, and now and then zero or oversize
   function automatic logic [lge_pkg::SIZE_W-1:0] pick_size();
      int roll;
      roll = $urandom_range(9, 0);
      if (roll == 0)
         return ($urandom_range(1, 0) == 0) ? 8'd0
                                            : lge_pkg::SIZE_W'($urandom_range(255, 129));
      else if (roll == 1)
         return lge_pkg::SIZE_W'($urandom_range(128, 13));
      return lge_pkg::SIZE_W'($urandom_range(12, 3));
   endfunction

   // Cell access on the default grid: in range, out of range, field extremes
   task automatic test_cell_access();
      send_request(lge_pkg::REQ_WRITE, 0, 0, 1'b1);
      send_request(lge_pkg::REQ_WRITE, 95, 95, 1'b1);
      send_request(lge_pkg::REQ_TOGGLE, 0, 0, 1'b0);
      send_request(lge_pkg::REQ_READ, 95, 95, 1'b0);
      send_request(lge_pkg::REQ_WRITE, 96, 5, 1'b1);
      send_request(lge_pkg::REQ_TOGGLE, 5, 96, 1'b1);
      send_request(lge_pkg::REQ_READ, 127, 127, 1'b1);
      send_request(lge_pkg::REQ_WRITE, 0, 0, 1'b0);
   endtask

   // Blinker against the grid edge: no wrap, and a read beyond the active area comes back out of range
   task automatic test_edge_blinker();
      set_grid_size(8'd4, 8'd4);
      for (int r = 0; r < 3; r++)
         send_request(lge_pkg::REQ_WRITE, 1, r, 1'b1);
      send_step();
      send_request(lge_pkg::REQ_READ, 0, 1, 1'b0);
      send_request(lge_pkg::REQ_READ, 1, 0, 1'b0);
      send_request(lge_pkg::REQ_READ, 95, 95, 1'b0);
   endtask

   // Oversize, zero and single-cell grids; stored cells persist across resizing
   task automatic test_size_extremes();
      set_grid_size(8'd255, 8'd128);
      send_request(lge_pkg::REQ_READ, 95, 95, 1'b0);
      send_request(lge_pkg::REQ_WRITE, 127, 127, 1'b1);
      send_step();
      send_request(lge_pkg::REQ_READ, 127, 127, 1'b0);
      set_grid_size(8'd0, 8'd1);
      send_request(lge_pkg::REQ_TOGGLE, 0, 0, 1'b1);
      send_step();
      set_grid_size(8'd1, 8'd1);
      send_request(lge_pkg::REQ_TOGGLE, 0, 0, 1'b0);
      send_step();
      send_request(lge_pkg::REQ_READ, 0, 0, 1'b0);
   endtask

   // Random phases: resize, seed cells, run generations, read back, some noise
   task automatic test_random_evolution();
      int stop_at;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         if (items_sent >= stop_at - 20)
            idling_on = 1'b0;
         set_grid_size(pick_size(), pick_size());
         repeat ($urandom_range(12, 3)) begin
            if ($urandom_range(9, 0) == 0)
               send_request(lge_pkg::REQ_W'($urandom_range(3, 0)),
                            int'($urandom_range(127, 0)), int'($urandom_range(127, 0)),
                            1'($urandom_range(1, 0)));
            else
               send_request(($urandom_range(3, 0) == 0) ? lge_pkg::REQ_TOGGLE
                                                        : lge_pkg::REQ_WRITE,
                            pick_coord(model_cols), pick_coord(model_rows),
                            ($urandom_range(2, 0) != 0));
         end
         repeat ($urandom_range(3, 1)) send_step();
         repeat ($urandom_range(6, 2)) begin
            if ($urandom_range(7, 0) == 0)
               send_request(lge_pkg::REQ_READ, int'($urandom_range(127, 0)),
                            int'($urandom_range(127, 0)), 1'($urandom_range(1, 0)));
            else
               send_request(lge_pkg::REQ_READ, pick_coord(model_cols),
                            pick_coord(model_rows), 1'($urandom_range(1, 0)));
         end
      end
   endtask

   // Result stall in random bursts, switched off for the closing stretch
   always @(negedge clock) begin
      if (reset || !idling_on) begin
         stall_left = 0;
      end else if (stall_left == 0 && $urandom_range(5, 0) == 0) begin
         stall_left = $urandom_range(8, 1);
      end
      rsp_stall = (stall_left > 0);
      if (stall_left > 0)
         stall_left--;
   end

   // Compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      life_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_error("result word arrived with none expected");
         end else begin
            want = expected_results.pop_front();
            if (rsp_cell_alive !== want.cell_alive)
               report_error($sformatf("cell_alive expected %0b got %0b",
                                      want.cell_alive, rsp_cell_alive));
            if (rsp_generation_done !== want.generation_done)
               report_error($sformatf("generation_done expected %0b got %0b",
                                      want.generation_done, rsp_generation_done));
            if (rsp_coord_out_of_range !== want.coord_out_of_range)
               report_error($sformatf("coord_out_of_range expected %0b got %0b",
                                      want.coord_out_of_range, rsp_coord_out_of_range));
         end
      end
   end

   // Bound the run length
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         report_error($sformatf("timeout with %0d result words outstanding",
                                expected_results.size()));
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_type        = lge_pkg::REQ_WRITE;
      req_cell_col    = '0;
      req_cell_row    = '0;
      req_write_value = 1'b0;
      rsp_stall       = 1'b0;
      csr_wr_en       = 1'b0;
      csr_index       = lge_pkg::CSR_ACTIVE_COLS;
      csr_wdata       = '0;
      for (int r = 0; r < GRID_SIDE; r++)
         life_cells[r] = '0;
      model_cols = lge_pkg::ACTIVE_COLS_RESET;
      model_rows = lge_pkg::ACTIVE_ROWS_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_cell_access();
      test_edge_blinker();
      test_size_extremes();
      test_random_evolution();

      wait_drain();
      repeat (20) @(negedge clock);
      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: sim.f
rtl/lge_pkg.sv
rtl/lge_ctrl.sv
rtl/lge_datapath.sv
rtl/life_grid_engine.sv
tb/life_grid_engine_tb.sv
